### hdl/pfpm_pkg.sv
// shared types, codes and constants for the page frame pool manager
package pfpm_pkg;

   localparam int NumFramesDef = 16;
   localparam int PageBitsDef  = 24;
   localparam int PinBitsDef   = 8;
   localparam int AgeBits      = 48;

   localparam logic [2:0] CMD_PIN      = 3'd0;
   localparam logic [2:0] CMD_UNPIN    = 3'd1;
   localparam logic [2:0] CMD_DIRTY    = 3'd2;
   localparam logic [2:0] CMD_FORCE    = 3'd3;
   localparam logic [2:0] CMD_FLUSH    = 3'd4;
   localparam logic [2:0] CMD_SHUTDOWN = 3'd5;

   localparam logic [2:0] ACT_DONE  = 3'd0;
   localparam logic [2:0] ACT_HIT   = 3'd1;
   localparam logic [2:0] ACT_READ  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_FULL  = 3'd4;

   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_FRAMES = 1'b1;

   typedef struct packed {
      logic [2:0]             cmd;
      logic [PageBitsDef-1:0] page_number;
   } req_word_type;

   typedef struct packed {
      logic [2:0]             action;
      logic [3:0]             frame_index;
      logic [PageBitsDef-1:0] page_out;
      logic                   last;
      logic [31:0]            reads_done;
      logic [31:0]            writes_done;
   } rsp_word_type;

endpackage

### hdl/pfpm_queue.sv
// two-entry command queue between the front end and the frame engine
module pfpm_queue
   import pfpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  req_word_type in_word,
   output logic         out_valid,
   input  logic         out_take,
   output req_word_type out_word
);
   req_word_type mem_ff [2];
   logic [0:0] wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_word  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_word;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

### hdl/pfpm_engine.sv
// frame table and command sequencer: lookup, victim search, flush walk
module pfpm_engine
   import pfpm_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDef,
   parameter int PIN_BITS   = PinBitsDef
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         policy,
   input  logic [4:0]   frames_cfg,
   input  logic         cmd_valid,
   output logic         cmd_take,
   input  req_word_type cmd_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);
   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int NP = 1 << FW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [PageBitsDef-1:0] page_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff, dirty_ff;
   logic [PIN_BITS-1:0]  pins_ff [NUM_FRAMES];
   logic [AgeBits-1:0]   age_ff  [NUM_FRAMES];
   logic [AgeBits-1:0]   clock_age_ff;
   logic [31:0] rd_cnt_ff, wr_cnt_ff;

   logic [2:0] state_ff;
   req_word_type cur_ff;
   logic [FW-1:0] vict_ff;
   logic [CW-1:0] walk_ff;
   logic any_ff;
   logic out_valid_ff;
   rsp_word_type out_ff;

   logic [CW-1:0] n_act;
   logic [NUM_FRAMES-1:0] in_use, match, match_pin, freev, cand, flushable;
   logic [FW-1:0] m_idx, mp_idx, f_idx, v_idx;
   logic m_hit, mp_hit, f_hit, v_hit;
   logic out_free, walk_end, more;
   logic [FW-1:0] walk_idx;

   // least-age tournament tree, leaves at NP and up
   logic [AgeBits-1:0] t_age [2*NP];
   logic [FW-1:0]      t_idx [2*NP];
   logic               t_ok  [2*NP];

   always_comb begin
      if (frames_cfg == 5'd0) n_act = CW'(1);
      else if ({27'd0, frames_cfg} > NUM_FRAMES) n_act = CW'(NUM_FRAMES);
      else n_act = CW'(frames_cfg);
   end

   always_comb begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
         in_use[i]    = (CW'(i) < n_act);
         match[i]     = in_use[i] && valid_ff[i]
                        && (page_ff[i] == cur_ff.page_number);
         match_pin[i] = match[i] && (pins_ff[i] != '0);
         freev[i]     = in_use[i] && !valid_ff[i];
         cand[i]      = in_use[i] && (pins_ff[i] == '0);
      end
   end

   // lowest-index priority pickers
   always_comb begin
      m_hit = 1'b0; m_idx = '0;
      mp_hit = 1'b0; mp_idx = '0;
      f_hit = 1'b0; f_idx = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (match[i])     begin m_hit = 1'b1;  m_idx = FW'(i);  end
         if (match_pin[i]) begin mp_hit = 1'b1; mp_idx = FW'(i); end
         if (freev[i])     begin f_hit = 1'b1;  f_idx = FW'(i);  end
      end
   end

   // victim search: pairwise least age, left (lower index) wins ties
   always_comb begin
      t_age[0] = '0; t_idx[0] = '0; t_ok[0] = 1'b0;
      for (int i = 0; i < NP; i++) begin
         t_idx[NP+i] = FW'(i);
         if (i < NUM_FRAMES) begin
            t_ok[NP+i]  = cand[i];
            t_age[NP+i] = age_ff[i];
         end else begin
            t_ok[NP+i]  = 1'b0;
            t_age[NP+i] = '0;
         end
      end
      for (int k = NP - 1; k >= 1; k--) begin
         if (t_ok[2*k] && (!t_ok[2*k+1] || t_age[2*k] <= t_age[2*k+1])) begin
            t_age[k] = t_age[2*k];
            t_idx[k] = t_idx[2*k];
         end else begin
            t_age[k] = t_age[2*k+1];
            t_idx[k] = t_idx[2*k+1];
         end
         t_ok[k] = t_ok[2*k] || t_ok[2*k+1];
      end
      v_hit = t_ok[1];
      v_idx = t_idx[1];
   end

   assign walk_idx = walk_ff[FW-1:0];
   always_comb begin
      for (int i = 0; i < NUM_FRAMES; i++)
         flushable[i] = valid_ff[i] && dirty_ff[i]
                        && ((cur_ff.cmd == CMD_SHUTDOWN) || (pins_ff[i] == '0));
   end
   // another write-back still ahead of the walk position
   always_comb begin
      more = 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++)
         if ((CW'(i) >= walk_ff) && in_use[i] && flushable[i]) more = 1'b1;
   end
   assign walk_end  = (walk_ff >= n_act);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign cmd_take  = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            pins_ff[i] <= '0;
            age_ff[i]  <= '0;
         end
         clock_age_ff <= '0;
         rd_cnt_ff    <= '0;
         wr_cnt_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff   <= cmd_word;
                  walk_ff  <= '0;
                  any_ff   <= 1'b0;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  out_valid_ff         <= 1'b1;
                  out_ff.last          <= 1'b1;
                  out_ff.page_out      <= cur_ff.page_number;
                  out_ff.frame_index   <= '0;
                  out_ff.action        <= ACT_DONE;
                  out_ff.reads_done    <= rd_cnt_ff;
                  out_ff.writes_done   <= wr_cnt_ff;
                  state_ff             <= ST_IDLE;
                  unique case (cur_ff.cmd)
                     CMD_PIN: begin
                        clock_age_ff <= clock_age_ff + 1'b1;
                        if (m_hit) begin
                           if (pins_ff[m_idx] != '1) pins_ff[m_idx] <= pins_ff[m_idx] + 1'b1;
                           if (policy) age_ff[m_idx] <= clock_age_ff + 1'b1;
                           out_ff.action      <= ACT_HIT;
                           out_ff.frame_index <= 4'(m_idx);
                        end else if (f_hit || (v_hit && !dirty_ff[v_idx])) begin
                           out_valid_ff <= 1'b0;
                           vict_ff  <= f_hit ? f_idx : v_idx;
                           state_ff <= ST_READ;
                        end else if (v_hit) begin
                           vict_ff  <= v_idx;
                           wr_cnt_ff <= wr_cnt_ff + 1'b1;
                           out_ff.writes_done <= wr_cnt_ff + 1'b1;
                           out_ff.action      <= ACT_WRITE;
                           out_ff.frame_index <= 4'(v_idx);
                           out_ff.page_out    <= page_ff[v_idx];
                           out_ff.last        <= 1'b0;
                           state_ff           <= ST_READ;
                        end else begin
                           out_ff.action <= ACT_FULL;
                        end
                     end
                     CMD_UNPIN: begin
                        if (mp_hit) begin
                           pins_ff[mp_idx]    <= pins_ff[mp_idx] - 1'b1;
                           out_ff.frame_index <= 4'(mp_idx);
                        end
                     end
                     CMD_DIRTY: begin
                        if (m_hit) begin
                           dirty_ff[m_idx]    <= 1'b1;
                           out_ff.frame_index <= 4'(m_idx);
                        end
                     end
                     CMD_FORCE: begin
                        if (m_hit) out_ff.frame_index <= 4'(m_idx);
                        if (m_hit && dirty_ff[m_idx]) begin
                           dirty_ff[m_idx]    <= 1'b0;
                           wr_cnt_ff          <= wr_cnt_ff + 1'b1;
                           out_ff.writes_done <= wr_cnt_ff + 1'b1;
                           out_ff.action      <= ACT_WRITE;
                           out_ff.page_out    <= page_ff[m_idx];
                        end
                     end
                     CMD_FLUSH, CMD_SHUTDOWN: begin
                        out_valid_ff <= 1'b0;
                        state_ff     <= ST_WALK;
                     end
                     default: ;
                  endcase
               end
            end
            ST_READ: begin
               if (out_free) begin
                  page_ff[vict_ff]  <= cur_ff.page_number;
                  valid_ff[vict_ff] <= 1'b1;
                  dirty_ff[vict_ff] <= 1'b0;
                  pins_ff[vict_ff]  <= PIN_BITS'(1);
                  age_ff[vict_ff]   <= clock_age_ff;
                  rd_cnt_ff         <= rd_cnt_ff + 1'b1;
                  out_valid_ff      <= 1'b1;
                  out_ff.action     <= ACT_READ;
                  out_ff.frame_index <= 4'(vict_ff);
                  out_ff.page_out   <= cur_ff.page_number;
                  out_ff.last       <= 1'b1;
                  out_ff.reads_done <= rd_cnt_ff + 1'b1;
                  out_ff.writes_done <= wr_cnt_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            ST_WALK: begin
               // one skipped frame a cycle; a write-back waits until the output slot is free
               if (walk_end) begin
                  state_ff <= ST_EMIT;
               end else if (!flushable[walk_idx]) begin
                  walk_ff <= walk_ff + 1'b1;
               end else if (out_free) begin
                  any_ff  <= 1'b1;
                  vict_ff <= walk_idx;
                  walk_ff <= walk_ff + 1'b1;
                  state_ff <= ST_EMIT;
               end
            end
            default: begin
               // ST_EMIT: the pending write-back, or done when the walk found nothing
               if (out_free) begin
                  out_valid_ff       <= 1'b1;
                  out_ff.reads_done  <= rd_cnt_ff;
                  if (!any_ff) begin
                     out_ff.action      <= ACT_DONE;
                     out_ff.frame_index <= '0;
                     out_ff.page_out    <= '0;
                     out_ff.last        <= 1'b1;
                     out_ff.writes_done <= wr_cnt_ff;
                     state_ff           <= ST_IDLE;
                  end else begin
                     out_ff.action      <= ACT_WRITE;
                     out_ff.frame_index <= 4'(vict_ff);
                     out_ff.page_out    <= page_ff[vict_ff];
                     out_ff.writes_done <= wr_cnt_ff + 1'b1;
                     wr_cnt_ff          <= wr_cnt_ff + 1'b1;
                     if (cur_ff.cmd != CMD_SHUTDOWN) dirty_ff[vict_ff] <= 1'b0;
                     // last write-back ends the command at once
                     out_ff.last <= !more;
                     state_ff    <= more ? ST_WALK : ST_IDLE;
                  end
               end
            end
         endcase
      end
   end
endmodule

### hdl/page_frame_pool_manager.sv
// top level: command front end, queue and frame engine of the page frame pool
//
// usage: send one command word on req_ (cmd, page_number) with req_valid;
// it is taken at an edge with req_valid high and req_stall low. each
// command yields one or more result words on rsp_, the final one with last
// set. every result word carries the read and write-back counts after it.
// a simple command's result word passes the queue, the engine's command
// register and its result register; a pin that reads a page also passes
// the read state, and a flush walks the frames one per cycle before its
// first word. the engine takes a command from the queue only when idle,
// so one command ends before the next starts; a pin that misses adds a
// read word, one more word on a dirty eviction, and flushes one per write-back.
// a two-word queue decouples the front end from the engine.
// csr_ writes set the policy (index 0) and frames in use (index 1); write
// them only while idle. reset empties the pool, zeroes the counters, sets
// FIFO policy and sixteen frames in use. if the receiver holds rsp_stall,
// the current result word holds and the engine waits; new commands still
// fill the queue until it is full, then req_stall rises.
module page_frame_pool_manager
   import pfpm_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDef,
   parameter int PIN_BITS   = PinBitsDef
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [4:0]   csr_data
);
   logic       policy_ff;
   logic [4:0] frames_ff;
   logic       q_valid, q_take;
   req_word_type q_word;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
         frames_ff <= 5'd16;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_POLICY: policy_ff <= csr_data[0];
            REG_FRAMES: frames_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // front end queue
   pfpm_queue u_queue (
      .clock, .reset,
      .in_valid (req_valid), .in_stall (req_stall), .in_word (req_word),
      .out_valid (q_valid), .out_take (q_take), .out_word (q_word)
   );

   // back end engine
   pfpm_engine #(
      .NUM_FRAMES (NUM_FRAMES), .PIN_BITS (PIN_BITS)
   ) u_engine (
      .clock, .reset,
      .policy (policy_ff), .frames_cfg (frames_ff),
      .cmd_valid (q_valid), .cmd_take (q_take), .cmd_word (q_word),
      .rsp_valid, .rsp_stall, .rsp_word
   );

   // a held result word must not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // a read result always includes its own read in the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_word.action == ACT_READ |-> rsp_word.reads_done != '0
      || $past(rsp_word.reads_done) == 32'hFFFF_FFFF)
      else $error("read result without read count");

   // a full pool reports frame zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.action == ACT_FULL |-> rsp_word.frame_index == '0 && rsp_word.last)
      else $error("no-free-frame result malformed");
endmodule

### dv/tb_page_frame_pool_manager.sv
// self-checking testbench for the page frame pool manager
module tb_page_frame_pool_manager
   import pfpm_pkg::*;
;

   // scoreboard: frame table predictor plus queue of expected result words
   class pool_scoreboard;
      logic [23:0] page_of[16];
      bit          valid_of[16];
      bit          dirty_of[16];
      int unsigned pins_of[16];
      logic [47:0] age_of[16];
      logic [47:0] age_now;
      logic [31:0] reads;
      logic [31:0] writes;
      bit          lru;
      int unsigned frames;
      rsp_word_type pending[$];
      int          errors;

      function void clear();
         for (int i = 0; i < 16; i++) begin
            valid_of[i] = 0; dirty_of[i] = 0; pins_of[i] = 0; age_of[i] = '0;
            page_of[i] = '0;
         end
         age_now = '0; reads = '0; writes = '0; lru = 0; frames = 16;
         pending.delete(); errors = 0;
      endfunction

      function void set_reg(logic idx, logic [4:0] val);
         if (idx == REG_POLICY) lru = val[0];
         else frames = val;
      endfunction

      function void push(logic [2:0] act, int f, logic [23:0] pg, bit lst);
         rsp_word_type w;
         w.action = act; w.frame_index = f[3:0]; w.page_out = pg; w.last = lst;
         w.reads_done = reads; w.writes_done = writes;
         pending.push_back(w);
      endfunction

      function int lookup(int n, logic [23:0] pg, bit need_pin);
         for (int i = 0; i < n; i++)
            if (valid_of[i] && page_of[i] == pg && (!need_pin || pins_of[i] > 0))
               return i;
         return -1;
      endfunction

      // note an accepted command word and queue its result words
      function void note_command(req_word_type c);
         int n, f, k;
         n = (frames == 0) ? 1 : (frames > 16 ? 16 : frames);
         f = -1;
         k = 0;
         case (c.cmd)
            CMD_PIN: begin
               age_now = age_now + 1;
               f = lookup(n, c.page_number, 0);
               if (f >= 0) begin
                  if (pins_of[f] < 255) pins_of[f]++;
                  if (lru) age_of[f] = age_now;
                  push(ACT_HIT, f, c.page_number, 1);
                  return;
               end
               for (int i = 0; i < n; i++)
                  if (!valid_of[i] && f < 0) f = i;
               if (f < 0) begin
                  // victim: oldest unpinned frame, lowest index on ties
                  for (int i = 0; i < n; i++)
                     if (pins_of[i] == 0 && (f < 0 || age_of[i] < age_of[f])) f = i;
                  if (f < 0) begin
                     push(ACT_FULL, 0, c.page_number, 1);
                     return;
                  end
                  if (dirty_of[f]) begin
                     writes++;
                     push(ACT_WRITE, f, page_of[f], 0);
                  end
               end
               reads++;
               page_of[f] = c.page_number; valid_of[f] = 1; dirty_of[f] = 0;
               pins_of[f] = 1; age_of[f] = age_now;
               push(ACT_READ, f, c.page_number, 1);
            end
            CMD_UNPIN: begin
               f = lookup(n, c.page_number, 1);
               if (f >= 0) pins_of[f]--;
               push(ACT_DONE, f < 0 ? 0 : f, c.page_number, 1);
            end
            CMD_DIRTY: begin
               f = lookup(n, c.page_number, 0);
               if (f >= 0) dirty_of[f] = 1;
               push(ACT_DONE, f < 0 ? 0 : f, c.page_number, 1);
            end
            CMD_FORCE: begin
               f = lookup(n, c.page_number, 0);
               if (f >= 0 && dirty_of[f]) begin
                  dirty_of[f] = 0;
                  writes++;
                  push(ACT_WRITE, f, page_of[f], 1);
               end else
                  push(ACT_DONE, f < 0 ? 0 : f, c.page_number, 1);
            end
            CMD_FLUSH, CMD_SHUTDOWN: begin
               for (int i = 0; i < n; i++)
                  if (valid_of[i] && dirty_of[i] &&
                      (c.cmd == CMD_SHUTDOWN || pins_of[i] == 0)) begin
                     writes++;
                     if (c.cmd == CMD_FLUSH) dirty_of[i] = 0;
                     push(ACT_WRITE, i, page_of[i], 0);
                     k++;
                  end
               if (k == 0) push(ACT_DONE, 0, '0, 1);
               else pending[pending.size() - 1].last = 1;
            end
            default: push(ACT_DONE, 0, c.page_number, 1);
         endcase
      endfunction

      // compare one received result word with the oldest expectation
      task check_result(rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result word");
            return;
         end
         want = pending.pop_front();
         if (got.action != want.action) report_mismatch("action");
         if (got.frame_index != want.frame_index) report_mismatch("frame_index");
         if (got.page_out != want.page_out) report_mismatch("page_out");
         if (got.last != want.last) report_mismatch("last");
         if (got.reads_done != want.reads_done) report_mismatch("reads_done");
         if (got.writes_done != want.writes_done) report_mismatch("writes_done");
      endtask

      task report_mismatch(string what);
         errors++;
         $display("mismatch: %s at %0t", what, $time);
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_word_type rsp_word;
   logic         csr_write = 0;
   logic         csr_index = 0;
   logic [4:0]   csr_data = '0;

   pool_scoreboard sb;
   bit           calm;         // long stretch with no idling on either side
   logic [23:0]  hot[8];       // small page set so pins hit and evict often

   page_frame_pool_manager DUT (.*);

   always #5 clock = ~clock;

   // result side: sample at the rising edge, vary stall at the falling edge
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);

   always @(negedge clock)
      rsp_stall <= (!calm && $urandom_range(99) < 7);

   // send one command word, with occasional idle cycles before it;
   // valid stays up on return so words can follow back to back
   task automatic send_word(logic [2:0] c, logic [23:0] pg);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_word <= '{cmd: c, page_number: pg};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_command(req_word);
      @(negedge clock);
   endtask

   // stop sending, wait for all expected words, then let the engine settle
   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [4:0] val);
      drain();
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic random_phase(int count);
      logic [2:0] c;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         // mostly pins, with unpin and dirty marks to keep the pool moving
         if (r < 45) c = CMD_PIN;
         else if (r < 70) c = CMD_UNPIN;
         else if (r < 83) c = CMD_DIRTY;
         else if (r < 90) c = CMD_FORCE;
         else if (r < 95) c = CMD_FLUSH;
         else if (r < 98) c = CMD_SHUTDOWN;
         else c = 3'($urandom_range(7, 6));
         send_word(c, ($urandom_range(9) == 0) ? 24'($urandom) : hot[$urandom_range(7)]);
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      calm = 0;
      for (int i = 0; i < 8; i++) hot[i] = 24'($urandom);
      hot[0] = 24'h000000;
      hot[1] = 24'hFFFFFF;
      repeat (3) @(negedge clock);
      reset <= 0;

      // directed: fill a four-frame pool, pin everything, force evictions
      write_reg(REG_FRAMES, 5'd4);
      for (int i = 0; i < 4; i++) send_word(CMD_PIN, hot[i]);
      send_word(CMD_PIN, hot[0]);           // hit
      send_word(CMD_PIN, hot[4]);           // all frames pinned
      send_word(CMD_DIRTY, hot[1]);
      send_word(CMD_SHUTDOWN, '0);          // pinned dirty frame written
      send_word(CMD_SHUTDOWN, '0);          // same frame again
      send_word(CMD_FLUSH, '0);             // pinned: nothing to write
      send_word(CMD_UNPIN, hot[1]);
      send_word(CMD_UNPIN, hot[1]);         // no pinned frame left
      send_word(CMD_PIN, hot[5]);           // evicts dirty frame
      send_word(CMD_DIRTY, hot[5]);
      send_word(CMD_FORCE, hot[5]);
      send_word(CMD_FORCE, hot[5]);         // clean now
      send_word(CMD_FORCE, 24'h123456);     // absent page
      send_word(3'd6, 24'hABCDEF);
      send_word(3'd7, 24'h000001);
      send_word(CMD_UNPIN, hot[2]);
      send_word(CMD_DIRTY, hot[2]);
      send_word(CMD_FLUSH, '0);

      write_reg(REG_POLICY, 5'd1);
      write_reg(REG_FRAMES, 5'd0);          // acts as one frame
      random_phase(25);
      write_reg(REG_FRAMES, 5'd31);         // clamps to sixteen
      random_phase(40);
      // sender pause until every expected word has come back
      drain();
      write_reg(REG_POLICY, 5'd0);
      write_reg(REG_FRAMES, 5'd3);
      calm = 1;
      random_phase(40);
      calm = 0;
      write_reg(REG_FRAMES, 5'd16);
      random_phase(40);
      write_reg(REG_POLICY, 5'd1);
      write_reg(REG_FRAMES, 5'd1);
      random_phase(25);
      write_reg(REG_FRAMES, 5'd6);
      random_phase(18);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
